### src/rtbfs_pkg.sv
// Shared types and constants for the radio tuning band filter select block.
// Depends on nothing; imported by the front, queue, back and top-level modules.
package rtbfs_pkg;

	localparam int FREQ_W   = 28;           // signed input frequency in hertz
	localparam int MAG_W    = FREQ_W - 1;   // magnitude of a non-negative frequency
	localparam int DIV_W    = 28;           // divisor width, covers 200 MHz plus offset
	localparam int OFFS_W   = 21;
	localparam int MASK_W   = 48;
	localparam int BPF_W    = 6;
	localparam int BYTE_W   = 8;
	localparam int AMP_W    = 3;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = 1;
	localparam int Q_CNT_W  = 2;

	localparam logic [DIV_W-1:0]  CLOCK_HZ   = 28'd200000000;
	localparam logic [MASK_W-1:0] SPUR_RESET = 48'hFFFF_0000_0000;
	localparam logic [BPF_W-1:0]  BPF_RESET  = 6'h20;

	// Configuration register indexes; each register sits at byte address 8*index.
	localparam logic [2:0] REG_FRONT  = 3'd0;
	localparam logic [2:0] REG_AMP    = 3'd1;
	localparam logic [2:0] REG_OFFSET = 3'd2;
	localparam logic [2:0] REG_SPUREN = 3'd3;
	localparam logic [2:0] REG_SPUR   = 3'd4;

	// One classified item on its way from the front to the divider.
	typedef struct packed {
		logic [BPF_W-1:0]  bpf;
		logic [BYTE_W-1:0] filt;
		logic [BYTE_W-1:0] lowpass;
		logic [AMP_W-1:0]  amp;
		logic [MAG_W-1:0]  freq;
		logic              zero;    // negative or zero frequency: tuning word is zero
	} item_t;

endpackage

### src/rtbfs_front.sv
// Front part: accepts frequencies, walks the filter ladders and keeps the shadow copies.
// Depends on rtbfs_pkg for field widths and the queue item type.
module rtbfs_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic signed [rtbfs_pkg::FREQ_W-1:0] freq_hz,
	input  logic                        front_end_fitted,
	input  logic                        amplifier_fitted,
	output logic                        q_wr,
	output rtbfs_pkg::item_t            q_data,
	input  logic                        q_full
);
	import rtbfs_pkg::*;

	localparam logic [MAG_W-1:0] T_2M5  = 27'd2500000;
	localparam logic [MAG_W-1:0] T_4M   = 27'd4000000;
	localparam logic [MAG_W-1:0] T_6M   = 27'd6000000;
	localparam logic [MAG_W-1:0] T_7M3  = 27'd7300000;
	localparam logic [MAG_W-1:0] T_12M  = 27'd12000000;
	localparam logic [MAG_W-1:0] T_14M5 = 27'd14500000;
	localparam logic [MAG_W-1:0] T_21M5 = 27'd21500000;
	localparam logic [MAG_W-1:0] T_24M  = 27'd24000000;
	localparam logic [MAG_W-1:0] T_30M  = 27'd30000000;
	localparam logic [MAG_W-1:0] T_36M  = 27'd36000000;
	localparam logic [MAG_W-1:0] T_65M  = 27'd65000000;

	logic [BPF_W-1:0]  bpf_q, bpf_n;
	logic [BYTE_W-1:0] filt_q, filt_n, lp_q, lp_n, keep;
	logic [AMP_W-1:0]  amp_q, amp_n;
	logic [1:0]        low2;
	logic              neg;
	logic [MAG_W-1:0]  f;

	assign neg  = freq_hz[FREQ_W-1];
	assign f    = freq_hz[MAG_W-1:0];
	assign full = q_full;
	assign q_wr = push && !q_full;

	always_comb begin
		bpf_n  = bpf_q;
		filt_n = filt_q;
		lp_n   = lp_q;
		amp_n  = amp_q;
		keep   = {6'b0, filt_q[1:0]};
		low2   = 2'b00;
		if (front_end_fitted) begin
			// Above 65 MHz the band-pass bits keep their previous value.
			if (neg)             filt_n = keep;
			else if (f < T_2M5)  filt_n = keep | 8'h80;
			else if (f < T_6M)   filt_n = keep | 8'h40;
			else if (f < T_12M)  filt_n = keep | 8'h10;
			else if (f < T_24M)  filt_n = keep | 8'h20;
			else if (f < T_36M)  filt_n = keep | 8'h08;
			else if (f <= T_65M) filt_n = keep | 8'h04;

			lp_n = 8'h00;
			if (neg)             lp_n = 8'h00;
			else if (f < T_2M5)  low2 = 2'b10;
			else if (f < T_4M)   lp_n = 8'h80;
			else if (f < T_6M)   lp_n = 8'h04;
			else if (f < T_7M3)  lp_n = 8'h20;
			else if (f < T_12M)  lp_n = 8'h10;
			else if (f < T_14M5) lp_n = 8'h08;
			else if (f < T_21M5) low2 = 2'b01;
			else if (f < T_30M)  lp_n = 8'h40;
			else if (f < T_65M)  lp_n = 8'h02;
			else                 lp_n = 8'h01;
			filt_n = {filt_n[7:2], low2};

			if (amplifier_fitted) begin
				if (neg || f > T_30M) amp_n = 3'd0;
				else if (f < T_2M5)   amp_n = 3'd6;
				else if (f < T_4M)    amp_n = 3'd5;
				else if (f < T_7M3)   amp_n = 3'd4;
				else if (f < T_14M5)  amp_n = 3'd3;
				else if (f < T_21M5)  amp_n = 3'd2;
				else                  amp_n = 3'd1;
			end
		end else begin
			if (neg)             bpf_n = 6'h00;
			else if (f < T_2M5)  bpf_n = 6'h01;
			else if (f < T_6M)   bpf_n = 6'h02;
			else if (f < T_12M)  bpf_n = 6'h08;
			else if (f < T_24M)  bpf_n = 6'h04;
			else if (f < T_36M)  bpf_n = 6'h10;
			else if (f <= T_65M) bpf_n = 6'h20;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpf_q  <= BPF_RESET;
			filt_q <= '0;
			lp_q   <= '0;
			amp_q  <= '0;
		end else if (q_wr) begin
			bpf_q  <= bpf_n;
			filt_q <= filt_n;
			lp_q   <= lp_n;
			amp_q  <= amp_n;
		end
	end

	always_comb begin
		q_data.bpf     = bpf_n;
		q_data.filt    = filt_n;
		q_data.lowpass = lp_n;
		q_data.amp     = amp_n;
		q_data.freq    = f;
		q_data.zero    = neg || (f == '0);
	end

endmodule

### src/rtbfs_queue.sv
// Short queue between the classifying front and the dividing back.
// Depends on rtbfs_pkg for the item type and the queue depth.
module rtbfs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  rtbfs_pkg::item_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output rtbfs_pkg::item_t rd_data,
	output logic             not_empty
);
	import rtbfs_pkg::*;

	item_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0]  cnt_q;
	logic                do_rd;

	assign full      = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr_en && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			slot_q[wr_ptr_q] <= wr_data;
	end

endmodule

### src/rtbfs_back.sv
// Back part: bit-serial restoring divider for the tuning word and the result register.
// Depends on rtbfs_pkg for the item type and field widths.
module rtbfs_back #(
	parameter int WORD_BITS = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_vld,
	input  rtbfs_pkg::item_t                 item,
	output logic                             item_pop,
	input  logic [rtbfs_pkg::DIV_W-1:0]      divisor,
	input  logic                             mask_en,
	input  logic [rtbfs_pkg::MASK_W-1:0]     mask,
	input  logic                             pop,
	output logic                             empty,
	output logic [rtbfs_pkg::BPF_W-1:0]      basic_bpf_bits,
	output logic [rtbfs_pkg::BYTE_W-1:0]     front_filter_byte,
	output logic [rtbfs_pkg::BYTE_W-1:0]     front_lowpass_byte,
	output logic [rtbfs_pkg::AMP_W-1:0]      amp_filter_code,
	output logic [WORD_BITS-1:0]             tuning_word
);
	import rtbfs_pkg::*;

	localparam int CNT_W = $clog2(WORD_BITS + 1);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [WORD_BITS-1:0] low_q, quo_q;
	item_t                hold_q;
	logic                 out_vld_q, load;
	logic [DIV_W:0]       trial;
	logic                 fits;
	logic [DIV_W-1:0]     start_rem;
	logic [WORD_BITS-1:0] start_low;

	// The dividend f*(2^W-1) is split as (f-1)*2^W + (2^W-f); since f is below the
	// divisor, f-1 is already the partial remainder and only W quotient bits remain.
	assign start_rem = item.zero ? '0 : (DIV_W'(item.freq) - 1'b1);
	assign start_low = item.zero ? '0 : ('0 - WORD_BITS'(item.freq));

	assign trial = {rem_q, low_q[WORD_BITS-1]};
	assign fits  = (trial >= {1'b0, divisor});

	assign item_pop = (state_q == ST_IDLE) && item_vld;
	assign load     = (state_q == ST_DONE) && (!out_vld_q || pop);
	assign empty    = !out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_vld) begin
						state_q <= ST_RUN;
						cnt_q   <= CNT_W'(WORD_BITS);
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load)
				out_vld_q <= 1'b1;
			else if (pop)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			hold_q <= item;
			rem_q  <= start_rem;
			low_q  <= start_low;
			quo_q  <= '0;
		end else if (state_q == ST_RUN) begin
			rem_q <= fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
			low_q <= {low_q[WORD_BITS-2:0], 1'b0};
			quo_q <= {quo_q[WORD_BITS-2:0], fits};
		end
		if (load) begin
			basic_bpf_bits     <= hold_q.bpf;
			front_filter_byte  <= hold_q.filt;
			front_lowpass_byte <= hold_q.lowpass;
			amp_filter_code    <= hold_q.amp;
			tuning_word        <= mask_en ? (quo_q & mask[WORD_BITS-1:0]) : quo_q;
		end
	end

endmodule

### src/radio_tuning_band_filter_select.sv
// Top level of the radio tuning band filter select block: register file and wiring.
// Depends on rtbfs_pkg, rtbfs_front, rtbfs_queue and rtbfs_back.
//
//   Channel   Handshake                 Payload
//   input     push / full               freq_hz
//   result    pop / empty               basic_bpf_bits, front_filter_byte,
//                                       front_lowpass_byte, amp_filter_code, tuning_word
//   config    psel/penable/pwrite/...   five registers at byte address 8*index
//
// An item passes from the queue head through the divider's run and done states to the result
// register; the shared bit-serial divider takes no new item before then, which sets the rate.
// The front classifies and updates the filter shadows in the cycle of the transfer.
// Two items can wait in the queue while the divider works and a result waits to be popped.
// Reset clears the registers to their defaults and the shadow band-pass bits to 0x20.
module radio_tuning_band_filter_select #(
	parameter int WORD_BITS = 48
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic signed [rtbfs_pkg::FREQ_W-1:0]     freq_hz,
	output logic                                    empty,
	input  logic                                    pop,
	output logic [rtbfs_pkg::BPF_W-1:0]             basic_bpf_bits,
	output logic [rtbfs_pkg::BYTE_W-1:0]            front_filter_byte,
	output logic [rtbfs_pkg::BYTE_W-1:0]            front_lowpass_byte,
	output logic [rtbfs_pkg::AMP_W-1:0]             amp_filter_code,
	output logic [WORD_BITS-1:0]                    tuning_word,
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [5:0]                              paddr,
	input  logic [63:0]                             pwdata,
	output logic [63:0]                             prdata,
	output logic                                    pready
);
	import rtbfs_pkg::*;

	logic                     front_q, amp_q, spur_en_q;
	logic signed [OFFS_W-1:0] offset_q;
	logic [MASK_W-1:0]        spur_q;
	logic                     wr;
	logic [2:0]               idx;
	logic [DIV_W-1:0]         divisor;
	logic                     q_wr, q_full, q_vld, q_pop;
	item_t                    q_in, q_out;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q   <= 1'b0;
			amp_q     <= 1'b0;
			offset_q  <= '0;
			spur_en_q <= 1'b0;
			spur_q    <= SPUR_RESET;
		end else if (wr) begin
			case (idx)
				REG_FRONT:  front_q   <= pwdata[0];
				REG_AMP:    amp_q     <= pwdata[0];
				REG_OFFSET: offset_q  <= pwdata[OFFS_W-1:0];
				REG_SPUREN: spur_en_q <= pwdata[0];
				REG_SPUR:   spur_q    <= pwdata[MASK_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_FRONT:  prdata = {63'b0, front_q};
			REG_AMP:    prdata = {63'b0, amp_q};
			REG_OFFSET: prdata = {{(64-OFFS_W){1'b0}}, offset_q};
			REG_SPUREN: prdata = {63'b0, spur_en_q};
			REG_SPUR:   prdata = {{(64-MASK_W){1'b0}}, spur_q};
			default:    prdata = '0;
		endcase
	end

	// The 21-bit signed offset stays within -1048576 to +1048575 Hz, so the sum is always positive and fits.
	assign divisor = CLOCK_HZ + DIV_W'(offset_q);

	rtbfs_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.freq_hz          (freq_hz),
		.front_end_fitted (front_q),
		.amplifier_fitted (amp_q),
		.q_wr             (q_wr),
		.q_data           (q_in),
		.q_full           (q_full)
	);

	rtbfs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (q_wr),
		.wr_data   (q_in),
		.full      (q_full),
		.rd_en     (q_pop),
		.rd_data   (q_out),
		.not_empty (q_vld)
	);

	rtbfs_back #(
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.item_vld           (q_vld),
		.item               (q_out),
		.item_pop           (q_pop),
		.divisor            (divisor),
		.mask_en            (spur_en_q),
		.mask               (spur_q),
		.pop                (pop),
		.empty              (empty),
		.basic_bpf_bits     (basic_bpf_bits),
		.front_filter_byte  (front_filter_byte),
		.front_lowpass_byte (front_lowpass_byte),
		.amp_filter_code    (amp_filter_code),
		.tuning_word        (tuning_word)
	);

endmodule

### src/rtbfs_checker.sv
// Port-level checks for radio_tuning_band_filter_select, attached by a bind statement.
// Depends only on the top level's ports.
module rtbfs_checker #(
	parameter int WORD_BITS = 48
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  push,
	input logic                  full,
	input logic                  empty,
	input logic                  pop,
	input logic [5:0]            basic_bpf_bits,
	input logic [7:0]            front_filter_byte,
	input logic [7:0]            front_lowpass_byte,
	input logic [2:0]            amp_filter_code,
	input logic [WORD_BITS-1:0]  tuning_word
);

	// Every field of a waiting result carries a defined value.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown({basic_bpf_bits, front_filter_byte, front_lowpass_byte,
			amp_filter_code, tuning_word}))
		else $error("waiting result holds unknown bits");

	a_bpf_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> $onehot0(basic_bpf_bits))
		else $error("basic band-pass select is not one-hot");

	a_lp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> $onehot0(front_lowpass_byte))
		else $error("front-end low-pass select is not one-hot");

	a_amp_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (amp_filter_code != 3'd7))
		else $error("PA low-pass code out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(tuning_word)))
		else $error("waiting result changed before its transfer");

endmodule

bind radio_tuning_band_filter_select rtbfs_checker #(.WORD_BITS(WORD_BITS)) u_chk (.*);
